@@ hw/rtl/ffhx_pkg.sv @@
package ffhx_pkg;

   // Frame and store geometry
   localparam int FRAME_BYTES = 32;
   localparam int STORE_BYTES = 64;
   localparam int HDR_BYTES   = 4;

   localparam logic [7:0] SYNC_BYTE = 8'hFF;

   // Byte positions inside a frame
   localparam int CMD_POS     = 8;
   localparam int FIELD_FIRST = 12;
   localparam int FIELD_LAST  = 27;

   localparam int PTR_W  = $clog2(STORE_BYTES);
   localparam int CNT_W  = $clog2(STORE_BYTES + 1);
   localparam int RUN_W  = $clog2(HDR_BYTES + 1);
   localparam int BODY_W = 8 * (FIELD_LAST - FIELD_FIRST + 1);

   // Ring address: base plus offset, folded back into the store
   function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] base,
                                                 input logic [CNT_W-1:0] offs);
      logic [CNT_W:0] sum;
      sum = {{(CNT_W + 1 - PTR_W){1'b0}}, base} + {1'b0, offs};
      if (sum >= (CNT_W + 1)'(STORE_BYTES)) begin
         sum = sum - (CNT_W + 1)'(STORE_BYTES);
      end
      return sum[PTR_W-1:0];
   endfunction

endpackage

@@ hw/rtl/ffhx_ram.sv @@
module ffhx_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write one entry, read one entry with registered data
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

@@ hw/rtl/ff_header_xor_frame_parser.sv @@
// Each input byte is written to the store. While fewer than four bytes are stored, the
// result is posted with no header hunt. Otherwise the store is hunted for a header,
// realigned and the result posted; an aligned full frame first has its checksum walked.
// No new byte is taken until the result for the last one is loaded, which waits for
// rsp_ready; the single frame RAM read port, walked one byte per cycle, sets the pace.
// Reset (synchronous, active high) empties the store and clears the command register.
module ff_header_xor_frame_parser (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_rx_byte,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_frame_valid,
   output logic [31:0]        rsp_anchor_id,
   output logic [31:0]        rsp_tag_id,
   output logic [31:0]        rsp_range_cm,
   output logic signed [15:0] rsp_azimuth,
   output logic signed [15:0] rsp_elevation,
   input  logic               csr_wr_en,
   input  logic [15:0]        csr_wr_data
);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SCAN   = 5'b00010,
      ST_ALIGN  = 5'b00100,
      ST_CHECK  = 5'b01000,
      ST_RESULT = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   logic [ffhx_pkg::PTR_W-1:0]  head_ff, head_in;
   logic [ffhx_pkg::CNT_W-1:0]  fill_ff, fill_in;
   logic [ffhx_pkg::CNT_W-1:0]  rd_pos_ff, rd_pos_in;
   logic [ffhx_pkg::CNT_W-1:0]  rd_idx_ff, rd_idx_in;
   logic                        rd_vld_ff, rd_vld_in;
   logic [ffhx_pkg::RUN_W-1:0]  run_ff, run_in;
   logic                        hdr_ok_ff, hdr_ok_in;
   logic                        pass_ff, pass_in;
   logic [7:0]                  xor_ff, xor_in;
   logic [15:0]                 cmd_ff, cmd_in;
   logic [ffhx_pkg::BODY_W-1:0] body_ff, body_in;
   logic [15:0]                 loc_cmd_ff;
   logic                        rsp_valid_ff, rsp_valid_in;

   logic                        ram_we;
   logic [ffhx_pkg::PTR_W-1:0]  ram_waddr;
   logic [ffhx_pkg::PTR_W-1:0]  ram_raddr;
   logic [7:0]                  ram_rdata;

   logic [ffhx_pkg::CNT_W-1:0]  rd_limit;
   logic                        issue;
   logic [ffhx_pkg::RUN_W-1:0]  run_next;
   logic [ffhx_pkg::CNT_W-1:0]  fill_inc;
   logic [ffhx_pkg::CNT_W-1:0]  shift;
   logic                        frame_ok;
   logic                        rsp_load;

   ffhx_ram #(
      .WIDTH (8),
      .DEPTH (ffhx_pkg::STORE_BYTES)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (req_rx_byte),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Read sequencing shared by the header hunt and the frame check
   assign rd_limit  = (state_ff == ST_CHECK) ? ffhx_pkg::CNT_W'(ffhx_pkg::FRAME_BYTES) : fill_ff;
   assign issue     = ((state_ff == ST_SCAN) || (state_ff == ST_CHECK)) && (rd_pos_ff < rd_limit);
   assign ram_raddr = ffhx_pkg::wrap_add(head_ff, rd_pos_ff);
   assign ram_waddr = ffhx_pkg::wrap_add(head_ff, fill_ff);
   assign run_next  = (ram_rdata == ffhx_pkg::SYNC_BYTE) ? run_ff + 1'b1 : '0;
   assign fill_inc  = fill_ff + 1'b1;
   assign shift     = rd_idx_ff - ffhx_pkg::CNT_W'(ffhx_pkg::HDR_BYTES - 1);
   assign frame_ok  = (xor_ff == ram_rdata) && (cmd_ff == loc_cmd_ff);

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      fill_in      = fill_ff;
      rd_pos_in    = issue ? rd_pos_ff + 1'b1 : rd_pos_ff;
      rd_idx_in    = rd_pos_ff;
      rd_vld_in    = issue;
      run_in       = run_ff;
      hdr_ok_in    = hdr_ok_ff;
      pass_in      = pass_ff;
      xor_in       = xor_ff;
      cmd_in       = cmd_ff;
      body_in      = body_ff;
      ram_we       = 1'b0;
      rsp_load     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               ram_we  = 1'b1;
               pass_in = 1'b0;
               if (fill_inc >= ffhx_pkg::CNT_W'(ffhx_pkg::STORE_BYTES)) begin
                  // store full: empty it, no frame
                  fill_in  = '0;
                  head_in  = '0;
                  state_in = ST_RESULT;
               end else if (fill_inc >= ffhx_pkg::CNT_W'(ffhx_pkg::HDR_BYTES)) begin
                  fill_in   = fill_inc;
                  rd_pos_in = '0;
                  run_in    = '0;
                  state_in  = ST_SCAN;
               end else begin
                  fill_in  = fill_inc;
                  state_in = ST_RESULT;
               end
            end
         end
         ST_SCAN: begin
            if (rd_vld_ff) begin
               run_in = run_next;
               if (run_next == ffhx_pkg::RUN_W'(ffhx_pkg::HDR_BYTES)) begin
                  // header found: move it to the front
                  head_in   = ffhx_pkg::wrap_add(head_ff, shift);
                  fill_in   = fill_ff - shift;
                  hdr_ok_in = 1'b1;
                  state_in  = ST_ALIGN;
               end
            end else if (rd_pos_ff >= fill_ff) begin
               // no header anywhere: drop the oldest byte
               head_in   = ffhx_pkg::wrap_add(head_ff, ffhx_pkg::CNT_W'(1));
               fill_in   = fill_ff - 1'b1;
               hdr_ok_in = 1'b0;
               state_in  = ST_ALIGN;
            end
         end
         ST_ALIGN: begin
            rd_vld_in = 1'b0;
            if (fill_ff >= ffhx_pkg::CNT_W'(ffhx_pkg::FRAME_BYTES)) begin
               if (hdr_ok_ff) begin
                  rd_pos_in = '0;
                  xor_in    = '0;
                  state_in  = ST_CHECK;
               end else begin
                  head_in  = ffhx_pkg::wrap_add(head_ff, ffhx_pkg::CNT_W'(1));
                  fill_in  = fill_ff - 1'b1;
                  state_in = ST_RESULT;
               end
            end else begin
               state_in = ST_RESULT;
            end
         end
         ST_CHECK: begin
            if (rd_vld_ff) begin
               if (rd_idx_ff == ffhx_pkg::CNT_W'(ffhx_pkg::FRAME_BYTES - 1)) begin
                  // last byte is the checksum
                  pass_in = frame_ok;
                  if (frame_ok) begin
                     fill_in = '0;
                     head_in = '0;
                  end else begin
                     head_in = ffhx_pkg::wrap_add(head_ff, ffhx_pkg::CNT_W'(1));
                     fill_in = fill_ff - 1'b1;
                  end
                  state_in = ST_RESULT;
               end else begin
                  xor_in = xor_ff ^ ram_rdata;
                  if ((rd_idx_ff == ffhx_pkg::CNT_W'(ffhx_pkg::CMD_POS)) ||
                      (rd_idx_ff == ffhx_pkg::CNT_W'(ffhx_pkg::CMD_POS + 1))) begin
                     cmd_in = {cmd_ff[7:0], ram_rdata};
                  end
                  if ((rd_idx_ff >= ffhx_pkg::CNT_W'(ffhx_pkg::FIELD_FIRST)) &&
                      (rd_idx_ff <= ffhx_pkg::CNT_W'(ffhx_pkg::FIELD_LAST))) begin
                     body_in = {body_ff[ffhx_pkg::BODY_W-9:0], ram_rdata};
                  end
               end
            end
         end
         ST_RESULT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold the result until the transfer completes
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         fill_ff      <= '0;
         rd_pos_ff    <= '0;
         rd_vld_ff    <= 1'b0;
         run_ff       <= '0;
         hdr_ok_ff    <= 1'b0;
         pass_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         loc_cmd_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         fill_ff      <= fill_in;
         rd_pos_ff    <= rd_pos_in;
         rd_vld_ff    <= rd_vld_in;
         run_ff       <= run_in;
         hdr_ok_ff    <= hdr_ok_in;
         pass_ff      <= pass_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            loc_cmd_ff <= csr_wr_data;
         end
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      rd_idx_ff <= rd_idx_in;
      xor_ff    <= xor_in;
      cmd_ff    <= cmd_in;
      body_ff   <= body_in;
   end

   // Load the result; fields read zero for a rejected byte
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_frame_valid <= pass_ff;
         rsp_anchor_id   <= pass_ff ? body_ff[127:96] : '0;
         rsp_tag_id      <= pass_ff ? body_ff[95:64]  : '0;
         rsp_range_cm    <= pass_ff ? body_ff[63:32]  : '0;
         rsp_azimuth     <= pass_ff ? body_ff[31:16]  : '0;
         rsp_elevation   <= pass_ff ? body_ff[15:0]   : '0;
      end
   end

`ifndef SYNTHESIS
   a_fill_below_store: assert property (@(posedge clock) disable iff (reset)
      fill_ff < ffhx_pkg::CNT_W'(ffhx_pkg::STORE_BYTES))
      else $error("fill count reached store capacity");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input ready right after a transfer");

   a_check_needs_frame: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CHECK |-> hdr_ok_ff && (fill_ff >= ffhx_pkg::CNT_W'(ffhx_pkg::FRAME_BYTES)))
      else $error("frame check without aligned full frame");

   a_good_frame_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_load && pass_ff |=> fill_ff == '0)
      else $error("store not emptied after good frame");

   a_zero_when_invalid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_frame_valid |-> (rsp_anchor_id == '0) && (rsp_tag_id == '0) &&
      (rsp_range_cm == '0) && (rsp_azimuth == '0) && (rsp_elevation == '0))
      else $error("nonzero fields on rejected result");
`endif

endmodule
